// ===== hw/rtl/pipc_pkg.sv =====
// Shared widths, register indexes and record types for the point-in-polygon
// crossing-number block. No dependencies; pipc_edge and the top level import it.
`default_nettype none

package pipc_pkg;

    // Coordinate width of the test point and of every vertex
    localparam int COORD_BITS   = 16;
    // A coordinate difference needs one more bit; a product of two needs twice that
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    // Configuration register index
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_Y = CFG_IDX_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // Directed edge from A to B
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

    typedef struct packed {
        logic inside_res;
        logic on_vertex;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/pipc_edge.sv =====
// Combinational crossing test of one polygon edge against the test point.
// Depends on pipc_pkg for coordinate, difference and product types.
`default_nettype none

module pipc_edge (
    input  pipc_pkg::t_point i_pt,
    input  pipc_pkg::t_edge  i_edge,
    output logic             o_cross
);
    import pipc_pkg::*;

    t_coord w_px, w_py, w_ax, w_ay, w_bx, w_by;
    logic   w_cond, w_pos;
    t_diff  w_dpx, w_dy, w_dpy, w_dx;
    t_prod  w_lhs, w_rhs;

    assign w_px = $signed(i_pt.x);
    assign w_py = $signed(i_pt.y);
    assign w_ax = $signed(i_edge.ax);
    assign w_ay = $signed(i_edge.ay);
    assign w_bx = $signed(i_edge.bx);
    assign w_by = $signed(i_edge.by);

    // Edge spans the horizontal line through the point, lower end inclusive
    assign w_cond = ((w_ay <= w_py) && (w_by > w_py)) || ((w_ay > w_py) && (w_by <= w_py));
    assign w_pos  = (w_by > w_py);

    // Differences, one bit wider than a coordinate
    assign w_dpx = DIFF_BITS'(w_px) - DIFF_BITS'(w_ax);
    assign w_dy  = DIFF_BITS'(w_by) - DIFF_BITS'(w_ay);
    assign w_dpy = DIFF_BITS'(w_py) - DIFF_BITS'(w_ay);
    assign w_dx  = DIFF_BITS'(w_bx) - DIFF_BITS'(w_ax);

    // Form (px-ax)*(by-ay) and (py-ay)*(bx-ax) exactly
    assign w_lhs = PROD_BITS'(w_dpx) * PROD_BITS'(w_dy);
    assign w_rhs = PROD_BITS'(w_dpy) * PROD_BITS'(w_dx);

    // Point left of the intersection; the compare flips for a downward edge
    assign o_cross = w_cond & (w_pos ? (w_lhs < w_rhs) : (w_rhs < w_lhs));

endmodule

`default_nettype wire

// ===== hw/rtl/point_in_polygon_crossing.sv =====
// Top level of the crossing-number point-in-polygon test: vertex stream in,
// one inside/outside verdict per polygon out. Depends on pipc_pkg, pipc_edge.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_ready   vertex_x, vertex_y, last_vertex
//   out      source     o_out_valid / i_out_ready inside_res, on_vertex
//   cfg      sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data (point_x, point_y)
//
// One vertex per cycle while o_in_ready is high. A vertex sits in the input
// register; both edge tests and the parity update are combinational from
// there, so a verdict goes into the output register, or into the skid register
// while the output is held. The two 17x17 products of each edge unit set the
// path. Reset is synchronous, active low; it clears the point, the polygon
// state and all valid flags. A held result parks in the output register and
// one more in a skid register; only with both full is o_in_ready low.
`default_nettype none

module point_in_polygon_crossing (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pipc_pkg::COORD_BITS-1:0]     i_in_vertex_x,
    input  logic [pipc_pkg::COORD_BITS-1:0]     i_in_vertex_y,
    input  logic                                i_in_last_vertex,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_out_inside_res,
    output logic                                o_out_on_vertex,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pipc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [pipc_pkg::COORD_BITS-1:0]     i_cfg_data
);
    import pipc_pkg::*;

    logic       w_adv;
    logic       w_in_acc;

    t_point     r_point;

    logic       r_s1_valid;
    t_coord     r_s1_x, r_s1_y;
    logic       r_s1_last;

    t_point     r_first, r_prev;
    logic       r_await;
    t_point     w_v, w_first;
    t_edge      w_edge0, w_edge1;
    logic       w_hit;

    logic       w_cross0, w_cross1;
    logic       r_par, r_hit;
    logic       w_par, w_hit_all;
    logic       w_res_valid;
    t_result    w_res;

    logic       r_out_valid, r_skid_valid;
    t_result    r_out, r_skid;

    // Advance unless the skid slot is occupied
    assign w_adv       = ~r_skid_valid;
    assign o_in_ready  = w_adv;
    assign w_in_acc    = i_in_valid & w_adv;
    assign o_cfg_ready = 1'b1;

    // Test point registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POINT_X: r_point.x <= i_cfg_data;
                CFG_POINT_Y: r_point.y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_x    <= i_in_vertex_x;
            r_s1_y    <= i_in_vertex_y;
            r_s1_last <= i_in_last_vertex;
        end
    end

    // Build the edge from the previous vertex and the closing edge
    assign w_v     = '{x: r_s1_x, y: r_s1_y};
    assign w_first = r_await ? w_v : r_first;
    assign w_hit   = (r_s1_x == r_point.x) && (r_s1_y == r_point.y);
    assign w_edge0 = '{ax: r_prev.x, ay: r_prev.y, bx: r_s1_x, by: r_s1_y};
    assign w_edge1 = '{ax: r_s1_x, ay: r_s1_y, bx: w_first.x, by: w_first.y};

    // Track first and previous vertex of the polygon
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_prev  <= '0;
            r_await <= 1'b1;
        end else if (w_adv && r_s1_valid) begin
            r_prev  <= w_v;
            if (r_await) begin
                r_first <= w_v;
            end
            r_await <= r_s1_last;
        end
    end

    pipc_edge u_edge_prev (
        .i_pt    (r_point),
        .i_edge  (w_edge0),
        .o_cross (w_cross0)
    );

    pipc_edge u_edge_close (
        .i_pt    (r_point),
        .i_edge  (w_edge1),
        .o_cross (w_cross1)
    );

    // Accumulate parity and vertex hits; close the polygon on the last vertex
    assign w_par       = r_par ^ (~r_await & w_cross0) ^ (r_s1_last & w_cross1);
    assign w_hit_all   = r_hit | w_hit;
    assign w_res_valid = w_adv & r_s1_valid & r_s1_last;
    assign w_res       = '{inside_res: w_par & ~w_hit_all, on_vertex: w_hit_all};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par <= 1'b0;
            r_hit <= 1'b0;
        end else if (w_adv && r_s1_valid) begin
            if (r_s1_last) begin
                r_par <= 1'b0;
                r_hit <= 1'b0;
            end else begin
                r_par <= w_par;
                r_hit <= w_hit_all;
            end
        end
    end

    // Output register with skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_res_valid;
            end
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_inside_res = r_out.inside_res;
    assign o_out_on_vertex  = r_out.on_vertex;

endmodule

`default_nettype wire

// ===== hw/rtl/pipc_checker.sv =====
// Port-level checks for point_in_polygon_crossing, attached by bind.
// Depends only on the top level's port names.
`default_nettype none

module pipc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic                                o_out_inside_res,
    input  logic                                o_out_on_vertex
);

    // A stalled result holds its verdict
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_inside_res)
            && $stable(o_out_on_vertex))
        else $error("result changed while stalled");

    // A point on a vertex is never reported inside
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_inside_res && o_out_on_vertex))
        else $error("inside and on_vertex both set");

    // Input back-pressure only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // The skid slot fills only when the output was held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready fell without a held result");

endmodule

bind point_in_polygon_crossing pipc_checker u_pipc_checker (.*);

`default_nettype wire
